[sv/bpe_pkg.sv]
// Shared constants, payload types, controller commands and helpers for the Bezier patch evaluator.
package bpe_pkg;

    localparam int MAX_ORDER     = 4;
    localparam int MIN_ORDER     = 2;
    localparam int DEFAULT_ORDER = 4;
    localparam int GRID_DEPTH    = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W        = $clog2(GRID_DEPTH);
    localparam int IDX_W         = $clog2(MAX_ORDER);
    localparam int ORD_W         = $clog2(MAX_ORDER + 1);

    localparam int COORD_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int PARAM_W  = 17;
    localparam int FIELD_W  = 2;
    localparam int NUM_AXES = 3;
    localparam int AX_X     = 0;
    localparam int AX_Y     = 1;
    localparam int AX_Z     = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_REG_W  = 3;

    localparam logic [PARAM_W-1:0]   ONE_Q16  = PARAM_W'(1 << FRAC_W);
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(1);
    localparam logic                 OP_LOAD  = 1'b0;
    localparam logic                 OP_EVAL  = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [NUM_AXES-1:0]     point_t;

    typedef struct packed {
        logic                      op;
        logic [FIELD_W-1:0]        row_index;
        logic [FIELD_W-1:0]        col_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [PARAM_W-1:0]        param_u;
        logic [PARAM_W-1:0]        param_v;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] surf_x;
        logic signed [COORD_W-1:0] surf_y;
        logic signed [COORD_W-1:0] surf_z;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_FILL,
        ST_REDUCE,
        ST_BUBBLE,
        ST_DRAIN,
        ST_SAVE,
        ST_VLOAD,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic              store_wr;
        logic              param_load;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic [IDX_W-1:0]  rd_col;
        logic              mul_en;
        logic [IDX_W-1:0]  mul_idx;
        logic              use_v;
        logic              row_save;
        logic [IDX_W-1:0]  row_sel;
        logic              v_load;
        logic              out_load;
    } dp_cmd_t;

    function automatic logic [ORD_W-1:0] clamp_order(input logic [CFG_REG_W-1:0] n);
        logic [ORD_W-1:0] r;
        if (int'(n) < MIN_ORDER)
            r = ORD_W'(MIN_ORDER);
        else if (int'(n) > MAX_ORDER)
            r = ORD_W'(MAX_ORDER);
        else
            r = ORD_W'(n);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] grid_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        return ADDR_W'(int'(row) * MAX_ORDER + int'(col));
    endfunction

endpackage

[sv/bezier_patch_evaluator_unit.sv]
// Top level of the Bezier patch evaluator: controller plus datapath.
//
// Channel  Handshake              Content
// in       in_valid / in_stall    in_data: load control point or evaluate at (u, v)
// out      out_valid / out_stall  out_data: surface point, one per evaluate transaction
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data: rows_in_use (0), cols_in_use (1)
//
// An evaluation reduces each row of control points along u, then the saved row results
// along v; its pace is set by the one shared lerp multiplier per axis and the
// single read port of the control point store. No clearing pass after reset.
// The finished point waits in the output register; the next transaction is taken meanwhile,
// and an evaluation whose result finds that register still full waits in its last state.
module bezier_patch_evaluator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  bpe_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output bpe_pkg::out_item_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bpe_pkg::*;

    dp_cmd_t cmd;

    bpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_op     (in_data.op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd)
    );

    bpe_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .out_data (out_data)
    );

endmodule

[sv/bpe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/bpe_ctrl.sv]
// Sequencing controller: config registers, handshakes and the de Casteljau schedule.
module bpe_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            in_op,
    output logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpe_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bpe_pkg::dp_cmd_t                cmd
);
    import bpe_pkg::*;

    ctrl_state_t          state_reg, state_next;
    logic [CFG_REG_W-1:0] rows_cfg_reg, rows_cfg_next;
    logic [CFG_REG_W-1:0] cols_cfg_reg, cols_cfg_next;
    logic [IDX_W-1:0]     row_reg, row_next;
    logic [IDX_W-1:0]     col_reg, col_next;
    logic [IDX_W-1:0]     level_reg, level_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 phase_v_reg, phase_v_next;
    logic                 out_valid_reg, out_valid_next;

    logic [ORD_W-1:0]     rows_n, cols_n;
    logic [IDX_W-1:0]     rows_last, cols_last;
    logic [IDX_W-1:0]     level_last;
    logic                 out_free;

    assign rows_n     = clamp_order(rows_cfg_reg);
    assign cols_n     = clamp_order(cols_cfg_reg);
    assign rows_last  = IDX_W'(rows_n - ORD_W'(1));
    assign cols_last  = IDX_W'(cols_n - ORD_W'(1));
    assign level_last = level_reg - IDX_W'(1);
    assign out_free   = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_op == OP_EVAL)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                if (col_reg == cols_last)
                    state_next = ST_FILL;
            end
            ST_FILL:
            begin
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (idx_reg == level_last)
                begin
                    if (level_reg == IDX_W'(1))
                        state_next = ST_DRAIN;
                    else if (level_reg == IDX_W'(2))
                        state_next = ST_BUBBLE;
                end
            end
            ST_BUBBLE:
            begin
                state_next = ST_REDUCE;
            end
            ST_DRAIN:
            begin
                state_next = phase_v_reg ? ST_DONE : ST_SAVE;
            end
            ST_SAVE:
            begin
                state_next = (row_reg == rows_last) ? ST_VLOAD : ST_READ;
            end
            ST_VLOAD:
            begin
                state_next = ST_REDUCE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.use_v    = phase_v_reg;
        cmd.rd_addr  = grid_addr(row_reg, col_reg);
        cmd.rd_col   = col_reg;
        cmd.mul_idx  = idx_reg;
        cmd.row_sel  = row_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.store_wr   = in_valid && in_op == OP_LOAD;
                cmd.param_load = in_valid && in_op == OP_EVAL;
            end
            ST_READ:   cmd.rd_en    = 1'b1;
            ST_REDUCE: cmd.mul_en   = 1'b1;
            ST_SAVE:   cmd.row_save = 1'b1;
            ST_VLOAD:  cmd.v_load   = 1'b1;
            ST_DONE:   cmd.out_load = out_free;
            default:   cmd.mul_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        rows_cfg_next  = rows_cfg_reg;
        cols_cfg_next  = cols_cfg_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        level_next     = level_reg;
        idx_next       = idx_reg;
        phase_v_next   = phase_v_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROWS: rows_cfg_next = cfg_data[CFG_REG_W-1:0];
                CFG_COLS: cols_cfg_next = cfg_data[CFG_REG_W-1:0];
                default:  rows_cfg_next = rows_cfg_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_op == OP_EVAL)
                begin
                    row_next     = '0;
                    col_next     = '0;
                    phase_v_next = 1'b0;
                end
            end
            ST_READ:
            begin
                if (col_reg == cols_last)
                begin
                    col_next   = '0;
                    level_next = cols_last;
                    idx_next   = '0;
                end
                else
                begin
                    col_next = col_reg + IDX_W'(1);
                end
            end
            ST_REDUCE:
            begin
                if (idx_reg == level_last)
                begin
                    idx_next   = '0;
                    level_next = level_last;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SAVE:
            begin
                row_next = row_reg + IDX_W'(1);
                col_next = '0;
            end
            ST_VLOAD:
            begin
                level_next   = rows_last;
                idx_next     = '0;
                phase_v_next = 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rows_cfg_reg  <= CFG_REG_W'(DEFAULT_ORDER);
            cols_cfg_reg  <= CFG_REG_W'(DEFAULT_ORDER);
            row_reg       <= '0;
            col_reg       <= '0;
            level_reg     <= '0;
            idx_reg       <= '0;
            phase_v_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_cfg_reg  <= rows_cfg_next;
            cols_cfg_reg  <= cols_cfg_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            level_reg     <= level_next;
            idx_reg       <= idx_next;
            phase_v_reg   <= phase_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("result not presented on leaving final state");

    a_reduce_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REDUCE) |-> (idx_reg < level_reg))
        else $error("lerp index beyond current level");

    a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && in_op == OP_EVAL)
        |=> (state_reg == ST_READ && row_reg == '0 && col_reg == '0))
        else $error("evaluation did not start at first row");

    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (col_reg <= cols_last && row_reg <= rows_last))
        else $error("control point read outside patch");

endmodule

[sv/bpe_datapath.sv]
// Datapath: control point store, working point registers and one lerp lane per axis.
module bpe_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  bpe_pkg::in_item_t   in_data,
    input  bpe_pkg::dp_cmd_t    cmd,
    output bpe_pkg::out_item_t  out_data
);
    import bpe_pkg::*;

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + PARAM_W + 1;

    logic [PARAM_W-1:0]       u_reg, v_reg;
    logic [PARAM_W-1:0]       u_clamped, v_clamped;
    logic                     fill_vld_reg;
    logic [IDX_W-1:0]         fill_col_reg;
    logic                     wb_vld_reg;
    logic [IDX_W-1:0]         wb_idx_reg;
    point_t                   w_reg  [MAX_ORDER];
    point_t                   rp_reg [MAX_ORDER];
    logic signed [PROD_W-1:0] prod_reg [NUM_AXES];
    logic signed [PROD_W-1:0] prod_next [NUM_AXES];
    coord_t                   base_reg [NUM_AXES];
    point_t                   wb_val;
    out_item_t                out_data_reg;

    logic                     wr_en;
    point_t                   wr_point;
    point_t                   rd_point;
    point_t                   op_a, op_b;
    logic [IDX_W-1:0]         idx_b;
    logic signed [PARAM_W:0]  t_s;
    logic signed [DIFF_W-1:0] diff [NUM_AXES];

    assign wr_en = cmd.store_wr && int'(in_data.row_index) < MAX_ORDER
                   && int'(in_data.col_index) < MAX_ORDER;

    always_comb
    begin
        wr_point       = '0;
        wr_point[AX_X] = in_data.point_x;
        wr_point[AX_Y] = in_data.point_y;
        wr_point[AX_Z] = in_data.point_z;
    end

    bpe_ram #(
        .WIDTH ($bits(point_t)),
        .DEPTH (GRID_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (grid_addr(IDX_W'(in_data.row_index), IDX_W'(in_data.col_index))),
        .wr_data (wr_point),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_point)
    );

    assign u_clamped = (in_data.param_u > ONE_Q16) ? ONE_Q16 : in_data.param_u;
    assign v_clamped = (in_data.param_v > ONE_Q16) ? ONE_Q16 : in_data.param_v;

    assign idx_b = cmd.mul_idx + IDX_W'(1);
    assign op_a  = w_reg[cmd.mul_idx];
    assign op_b  = w_reg[idx_b];
    assign t_s   = $signed({1'b0, cmd.use_v ? v_reg : u_reg});

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            diff[k] = $signed({op_b[k][COORD_W-1], op_b[k]})
                      - $signed({op_a[k][COORD_W-1], op_a[k]});
            prod_next[k] = diff[k] * t_s;
            wb_val[k] = base_reg[k] + coord_t'(prod_reg[k][COORD_W+FRAC_W-1:FRAC_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_vld_reg <= 1'b0;
            wb_vld_reg   <= 1'b0;
        end
        else
        begin
            fill_vld_reg <= cmd.rd_en;
            wb_vld_reg   <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_col_reg <= cmd.rd_col;
        wb_idx_reg   <= cmd.mul_idx;
        if (cmd.param_load)
        begin
            u_reg <= u_clamped;
            v_reg <= v_clamped;
        end
        if (cmd.mul_en)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                prod_reg[k] <= prod_next[k];
                base_reg[k] <= op_a[k];
            end
        end
        if (fill_vld_reg)
        begin
            w_reg[fill_col_reg] <= rd_point;
        end
        if (wb_vld_reg)
        begin
            w_reg[wb_idx_reg] <= wb_val;
        end
        if (cmd.v_load)
        begin
            w_reg <= rp_reg;
        end
        if (cmd.row_save)
        begin
            rp_reg[cmd.row_sel] <= w_reg[0];
        end
        if (cmd.out_load)
        begin
            out_data_reg.surf_x <= w_reg[0][AX_X];
            out_data_reg.surf_y <= w_reg[0][AX_Y];
            out_data_reg.surf_z <= w_reg[0][AX_Z];
        end
    end

    assign out_data = out_data_reg;

endmodule
